FILE: src/sdtq_pkg.sv
// Package: shared types and constants for the sorted delay timer queue.
`timescale 1ns / 1ps
package sdtq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TICK_W = 31;
  localparam int TASK_W = 8;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  typedef enum logic [2:0] {
    FUNC_TIME  = 3'd0,
    FUNC_DELAY = 3'd1,
    FUNC_UNTIL = 3'd2,
    FUNC_TICK  = 3'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NEG     = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_req;   // capture request fields
    logic       tick_inc;   // saturating advance of now
    logic       scan_top;   // scan index to entry count, capture new wake
    logic       shift_up;   // move entry at scan-1 into scan, scan decrements
    logic       write_new;  // write new entry at scan index, count++
    logic       pop_front;  // drop head entry (one-step shift down)
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       full;
    logic       empty;
    logic       scan_end;   // scan index at zero
    logic       scan_le;    // entry below scan index <= new wake
    logic       head_due;   // head wake <= now
    logic       negative;
  } dp_stat_t;
endpackage

FILE: src/sdtq_if.sv
// Interfaces: valid/ready request and reply channels.
`timescale 1ns / 1ps
interface sdtq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  requester;
  logic signed [31:0] ticks;
  modport source (output valid, func, requester, ticks, input ready);
  modport sink (input valid, func, requester, ticks, output ready);
endinterface

interface sdtq_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_to;
  logic [30:0] reply_time;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, reply_to, reply_time, status, last, input ready);
  modport sink (input valid, reply_to, reply_time, status, last, output ready);
endinterface

FILE: src/sorted_delay_timer_queue_unit.sv
// Top level: sorted delay timer queue with request and reply channels.
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | func[2:0], requester[7:0], ticks[31:0] signed
// rsp     | out | reply_to[7:0], reply_time[30:0], status[1:0], last
// One request at a time: ready is high only in idle.
// Query, invalid or rejected delay or until: decode, reply, then wait before the next accept.
// Delay or until: decode, then one shift step per queued entry with a later wake, then the write.
// Tick: decode, one reply per expired entry, a final reply, then wait; a stalled reply adds its wait.
// Synchronous reset clears the tick count, the entry count and reply valid.
module sorted_delay_timer_queue_unit (
  input logic        clk,
  input logic        rst,
  sdtq_req_if.sink   req,
  sdtq_rsp_if.source rsp
);
  sdtq_pkg::dp_cmd_t  cmd;
  sdtq_pkg::dp_stat_t stat;
  logic [2:0]  func;
  logic [7:0]  requester;
  logic [7:0]  head_task;
  logic [30:0] now_tick;

  sdtq_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .func_in(req.func), .requester_in(req.requester), .ticks_in(req.ticks),
    .func, .requester, .head_task, .now_tick
  );

  sdtq_ctrl u_ctrl (
    .clk, .rst, .req, .rsp, .cmd, .stat, .func, .requester, .head_task, .now_tick
  );
endmodule

FILE: src/sdtq_datapath.sv
// Datapath: tick counter, sorted entry registers, scan index and request capture.
`timescale 1ns / 1ps
module sdtq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sdtq_pkg::dp_cmd_t             cmd,
  output sdtq_pkg::dp_stat_t            stat,
  input  logic [2:0]                    func_in,
  input  logic [sdtq_pkg::TASK_W-1:0]   requester_in,
  input  logic [31:0]                   ticks_in,
  output logic [2:0]                    func,
  output logic [sdtq_pkg::TASK_W-1:0]   requester,
  output logic [sdtq_pkg::TASK_W-1:0]   head_task,
  output logic [sdtq_pkg::TICK_W-1:0]   now_tick
);
  logic [sdtq_pkg::TICK_W-1:0] entry_wake [sdtq_pkg::QUEUE_DEPTH];
  logic [sdtq_pkg::TASK_W-1:0] entry_task [sdtq_pkg::QUEUE_DEPTH];
  logic [sdtq_pkg::CNT_W-1:0]  count;
  logic [sdtq_pkg::CNT_W-1:0]  scan;
  logic [31:0]                 ticks;
  logic [sdtq_pkg::TICK_W-1:0] wake;
  logic [sdtq_pkg::TICK_W:0]   wake_sum;
  logic [sdtq_pkg::IDX_W-1:0]  sidx;
  logic [sdtq_pkg::IDX_W-1:0]  sprev;

  assign wake_sum = {1'b0, now_tick} + {1'b0, ticks[sdtq_pkg::TICK_W-1:0]};
  assign sidx = scan[sdtq_pkg::IDX_W-1:0];
  assign sprev = sidx - 1'b1;

  assign stat.full = (count == sdtq_pkg::CNT_W'(sdtq_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.scan_end = (scan == '0);
  assign stat.scan_le = (entry_wake[sprev] <= wake);
  assign stat.head_due = (entry_wake[0] <= now_tick);
  assign stat.negative = ticks[31];
  assign head_task = entry_task[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      now_tick <= '0;
      count <= '0;
      scan <= '0;
    end else begin
      if (cmd.tick_inc && now_tick != sdtq_pkg::TICK_MAX) now_tick <= now_tick + 1'b1;
      if (cmd.scan_top) scan <= count;
      else if (cmd.shift_up) scan <= scan - 1'b1;
      if (cmd.write_new) count <= count + 1'b1;
      else if (cmd.pop_front) count <= count - 1'b1;
    end
  end

  // Insert: walk down from count, shifting later wakes up, then write the gap.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func <= func_in;
      requester <= requester_in;
      ticks <= ticks_in;
    end
    if (cmd.scan_top) begin
      if (func == sdtq_pkg::FUNC_DELAY)
        wake <= wake_sum[sdtq_pkg::TICK_W] ? sdtq_pkg::TICK_MAX
                                           : wake_sum[sdtq_pkg::TICK_W-1:0];
      else
        wake <= ticks[sdtq_pkg::TICK_W-1:0];
    end
    if (cmd.shift_up) begin
      entry_wake[sidx] <= entry_wake[sprev];
      entry_task[sidx] <= entry_task[sprev];
    end else if (cmd.write_new) begin
      entry_wake[sidx] <= wake;
      entry_task[sidx] <= requester;
    end else if (cmd.pop_front) begin
      for (int i = 0; i < sdtq_pkg::QUEUE_DEPTH - 1; i++) begin
        entry_wake[i] <= entry_wake[i+1];
        entry_task[i] <= entry_task[i+1];
      end
    end
  end
endmodule

FILE: src/sdtq_ctrl.sv
// Controller: request decode, insert shift sequencing and tick reply sequencing.
`timescale 1ns / 1ps
module sdtq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  sdtq_req_if.sink                      req,
  sdtq_rsp_if.source                    rsp,
  output sdtq_pkg::dp_cmd_t             cmd,
  input  sdtq_pkg::dp_stat_t            stat,
  input  logic [2:0]                    func,
  input  logic [sdtq_pkg::TASK_W-1:0]   requester,
  input  logic [sdtq_pkg::TASK_W-1:0]   head_task,
  input  logic [sdtq_pkg::TICK_W-1:0]   now_tick
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SHIFT, S_EXPIRE, S_REPLY, S_WAIT
  } state_t;

  state_t state;
  logic   rsp_valid;
  logic [7:0] rsp_to;
  logic [sdtq_pkg::TICK_W-1:0] rsp_time;
  logic [1:0] rsp_status;
  logic   rsp_last;
  logic   out_free;
  logic   rsp_load;
  logic   expire_head;
  sdtq_pkg::status_t reply_code;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.reply_to = rsp_to;
  assign rsp.reply_time = rsp_time;
  assign rsp.status = rsp_status;
  assign rsp.last = rsp_last;
  assign out_free = !rsp_valid || rsp.ready;
  assign expire_head = !stat.empty && stat.head_due;

  always_comb begin
    cmd = '0;
    rsp_load = 1'b0;
    priority if (func == sdtq_pkg::FUNC_TIME || func == sdtq_pkg::FUNC_TICK)
      reply_code = sdtq_pkg::ST_OK;
    else if (func == sdtq_pkg::FUNC_DELAY || func == sdtq_pkg::FUNC_UNTIL) begin
      if (stat.negative) reply_code = sdtq_pkg::ST_NEG;
      else reply_code = sdtq_pkg::ST_FULL;
    end else reply_code = sdtq_pkg::ST_INVALID;
    unique case (state)
      S_IDLE: cmd.load_req = req.valid;
      S_DECODE: begin
        cmd.scan_top = 1'b1;
        cmd.tick_inc = (func == sdtq_pkg::FUNC_TICK);
      end
      S_SHIFT: begin
        if (stat.scan_end || stat.scan_le) cmd.write_new = 1'b1;
        else cmd.shift_up = 1'b1;
      end
      S_EXPIRE: begin
        rsp_load = out_free;
        cmd.pop_front = out_free && expire_head;
      end
      S_REPLY: rsp_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
      // Hold the reply time so a later tick cannot move a waiting reply.
      if (rsp_load) begin
        rsp_time <= now_tick;
        if (state == S_EXPIRE && expire_head) begin
          rsp_to <= head_task;
          rsp_status <= sdtq_pkg::ST_OK;
          rsp_last <= 1'b0;
        end else begin
          rsp_to <= requester;
          rsp_status <= reply_code;
          rsp_last <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: if (req.valid) state <= S_DECODE;
        S_DECODE: begin
          priority if (func == sdtq_pkg::FUNC_TIME) state <= S_REPLY;
          else if (func == sdtq_pkg::FUNC_TICK) state <= S_EXPIRE;
          else if (func == sdtq_pkg::FUNC_DELAY || func == sdtq_pkg::FUNC_UNTIL) begin
            if (stat.negative || stat.full) state <= S_REPLY;
            else state <= S_SHIFT;
          end else state <= S_REPLY;
        end
        S_SHIFT: if (stat.scan_end || stat.scan_le) state <= S_IDLE;
        S_EXPIRE: if (out_free && !expire_head) state <= S_WAIT;
        S_REPLY: if (out_free) state <= S_WAIT;
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !(state == S_SHIFT)) else $error("ready while shifting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("reply dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=>
      $stable({rsp.reply_to, rsp.reply_time, rsp.status, rsp.last}))
    else $error("reply changed while waiting");
  a_noins_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write_new |-> !stat.full) else $error("insert into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_front |-> !stat.empty) else $error("pop from empty queue");
endmodule
